@@ rtl/core/pwcf_pkg.sv @@
// Shared types and constants for the PID core with command filter.
// Used by the divider, the multiplier and the top level; no dependencies.
`default_nettype none

package pwcf_pkg;

    localparam int DATA_W      = 32;
    localparam int TIME_W      = 20;
    localparam int LIMIT_W     = 31;
    localparam int INTEG_W     = 48;
    localparam int SUM_W       = 21;
    localparam int DIV_NUM_W   = 53;
    localparam int CFG_INDEX_W = 3;
    localparam int S_TDATA_W   = 120;
    localparam int M_TDATA_W   = 32;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_GAIN_PROP,
        REG_GAIN_INTEG,
        REG_GAIN_DERIV,
        REG_FILTER_TC,
        REG_CMD_LIMIT
    } cfg_reg_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_CMD,
        S_MUL_FILT,
        S_SUM_NUM,
        S_DIV_RATE,
        S_WAIT_RATE,
        S_DIV_FILT,
        S_WAIT_FILT,
        S_ERR,
        S_MUL_P,
        S_INTEG,
        S_MUL_KD,
        S_MUL_KI_HI,
        S_MUL_KI_LO,
        S_RESULT
    } state_t;

    // Operand request to the shared magnitude multiplier
    typedef struct packed {
        logic              en;
        logic              neg;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
    } mul_req_t;

endpackage

`default_nettype wire

@@ rtl/core/pwcf_div.sv @@
// Restoring serial divider, one quotient bit per cycle, unsigned operands.
// Depends on pwcf_pkg for default widths.
`default_nettype none

module pwcf_div
    import pwcf_pkg::*;
#(
    parameter int NUM_W = DIV_NUM_W,
    parameter int DEN_W = SUM_W
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic                  done,
    output logic      [NUM_W-1:0] quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [DEN_W-1:0] den_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] rem_next;
    logic [NUM_W-1:0] quo_reg;
    logic [NUM_W-1:0] quo_next;
    logic [CNT_W-1:0] cnt_reg;
    logic             done_reg;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   trial_sub;
    logic             fits;

    always_comb begin
        trial     = {rem_reg, quo_reg[NUM_W-1]};
        trial_sub = trial - {1'b0, den_reg};
        fits      = (trial >= {1'b0, den_reg});
        rem_next  = fits ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
        quo_next  = {quo_reg[NUM_W-2:0], fits};
    end

    // Dividend shifts out at the top while quotient bits shift in at the bottom
    always_ff @(posedge aclk) begin
        if (start) begin
            den_reg <= den;
            rem_reg <= '0;
            quo_reg <= num;
        end else if (cnt_reg != '0) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else if (start) begin
            cnt_reg  <= CNT_W'(NUM_W);
            done_reg <= 1'b0;
        end else if (cnt_reg != '0) begin
            cnt_reg  <= cnt_reg - 1'b1;
            done_reg <= (cnt_reg == CNT_W'(1));
        end else begin
            done_reg <= 1'b0;
        end
    end

    assign done = done_reg;
    assign quot = quo_reg;

endmodule

`default_nettype wire

@@ rtl/core/pwcf_mul.sv @@
// Shared 32x32 unsigned multiplier with a registered product and sign.
// Depends on pwcf_pkg for the request struct.
`default_nettype none

module pwcf_mul
    import pwcf_pkg::*;
(
    input  wire logic                aclk,
    input  wire mul_req_t            req,
    output logic [2*DATA_W-1:0]      prod,
    output logic                     neg
);

    logic [2*DATA_W-1:0] prod_reg;
    logic                neg_reg;

    always_ff @(posedge aclk) begin
        if (req.en) begin
            prod_reg <= (2*DATA_W)'(req.a) * (2*DATA_W)'(req.b);
            neg_reg  <= req.neg;
        end
    end

    assign prod = prod_reg;
    assign neg  = neg_reg;

endmodule

`default_nettype wire

@@ rtl/core/pid_with_command_filter_core.sv @@
// PID core with command clamp and first-order command filter, Q16.16.
// Each beat runs the sequencer through two serial divisions of a 53-bit dividend;
// both are skipped when time_step plus filter_time_const is zero.
// One beat is in flight at a time: s_tready rises in the idle state after the result
// register load, which waits while m_tvalid is high and m_tready is low.
// Reset: synchronous, active-low aresetn clears gains, filter state and integral.
`default_nettype none

module pid_with_command_filter_core
    import pwcf_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    // s_tdata: command[31:0], measured[63:32], measured_rate[95:64],
    //          time_step[115:96], zero fill[119:116]
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [S_TDATA_W-1:0]   s_tdata,
    // m_tdata: drive[31:0]
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic      [M_TDATA_W-1:0]   m_tdata,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [DATA_W-1:0]      cfg_data
);

    // ---------------- helpers ----------------
    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        mag32 = v[31] ? 32'(-v) : v;
    endfunction

    function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
        if (v[32] != v[31]) sat33 = v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        else sat33 = v[31:0];
    endfunction

    function automatic logic signed [31:0] sat_quot(input logic neg,
                                                     input logic [DIV_NUM_W-1:0] q);
        if (neg) begin
            if (q > DIV_NUM_W'(64'h8000_0000)) sat_quot = 32'sh8000_0000;
            else sat_quot = -$signed(q[31:0]);
        end else begin
            if (q > DIV_NUM_W'(64'h7FFF_FFFF)) sat_quot = 32'sh7FFF_FFFF;
            else sat_quot = $signed(q[31:0]);
        end
    endfunction

    // ---------------- registers ----------------
    state_t state_reg, state_next;

    logic [DATA_W-1:0]         kp_reg, ki_reg, kd_reg;
    logic [TIME_W-1:0]         tau_reg;
    logic [LIMIT_W-1:0]        lim_reg;

    logic signed [31:0]        cmd_reg, meas_reg, mrate_reg;
    logic [TIME_W-1:0]         dt_reg;
    logic [SUM_W-1:0]          sum_reg;

    logic signed [31:0]        filt_reg, rate_reg;
    logic signed [INTEG_W-1:0] integ_reg;
    logic signed [31:0]        p_reg, d_reg;
    logic signed [53:0]        num_reg;
    logic signed [48:0]        acc_reg;
    logic [63:0]               ki_hi_reg;

    logic                      m_tvalid_reg;
    logic [M_TDATA_W-1:0]      m_tdata_reg;

    // ---------------- input side ----------------
    logic signed [31:0]  in_cmd;
    logic signed [32:0]  in_cmd33, lim33, neg_lim33;
    logic signed [31:0]  in_cmd_clamped;
    logic [TIME_W-1:0]   in_dt;
    logic [SUM_W-1:0]    in_sum;
    logic                in_accept;

    always_comb begin
        in_cmd    = $signed(s_tdata[31:0]);
        in_dt     = s_tdata[115:96];
        in_sum    = {1'b0, in_dt} + {1'b0, tau_reg};
        in_cmd33  = {in_cmd[31], in_cmd};
        lim33     = $signed({2'b00, lim_reg});
        neg_lim33 = -lim33;
        if (lim_reg != '0 && in_cmd33 > lim33) in_cmd_clamped = lim33[31:0];
        else if (lim_reg != '0 && in_cmd33 < neg_lim33) in_cmd_clamped = neg_lim33[31:0];
        else in_cmd_clamped = in_cmd;
    end

    assign in_accept = s_tvalid && s_tready;

    // ---------------- shared units ----------------
    mul_req_t            mul_req;
    logic [63:0]         mul_prod;
    logic                mul_neg;
    logic                div_start;
    logic                div_done;
    logic [DIV_NUM_W-1:0] div_num;
    logic [DIV_NUM_W-1:0] div_quot;

    pwcf_mul u_mul (
        .aclk (aclk),
        .req  (mul_req),
        .prod (mul_prod),
        .neg  (mul_neg)
    );

    pwcf_div #(
        .NUM_W (DIV_NUM_W),
        .DEN_W (SUM_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (sum_reg),
        .done    (div_done),
        .quot    (div_quot)
    );

    // ---------------- datapath terms ----------------
    logic signed [32:0]  diff33;
    logic [32:0]         diff_mag;
    logic [53:0]         num_mag;
    logic signed [64:0]  prod_s;
    logic signed [48:0]  q16_s;
    logic signed [48:0]  integ_wide;
    logic [INTEG_W-1:0]  integ_mag;
    logic [63:0]         ki_m, ki_capped;
    logic signed [64:0]  ki_term, total;
    logic signed [31:0]  drive;
    logic                out_load;

    always_comb begin
        diff33     = {cmd_reg[31], cmd_reg} - {filt_reg[31], filt_reg};
        diff_mag   = diff33[32] ? 33'(-diff33) : diff33;
        num_mag    = num_reg[53] ? 54'(-num_reg) : num_reg;
        div_num    = (state_reg == S_DIV_RATE) ? {4'b0000, diff_mag, 16'h0000}
                                               : num_mag[DIV_NUM_W-1:0];
        prod_s     = mul_neg ? -$signed({1'b0, mul_prod}) : $signed({1'b0, mul_prod});
        q16_s      = mul_neg ? -$signed({1'b0, mul_prod[63:16]})
                             : $signed({1'b0, mul_prod[63:16]});
        integ_wide = {integ_reg[INTEG_W-1], integ_reg} + q16_s;
        integ_mag  = integ_reg[INTEG_W-1] ? INTEG_W'(-integ_reg) : integ_reg;
        // Cap the integral term at 2^62; anything that large saturates the output
        ki_m       = ki_hi_reg + {16'h0000, mul_prod[63:16]};
        ki_capped  = (ki_m > 64'h4000_0000_0000_0000) ? 64'h4000_0000_0000_0000 : ki_m;
        ki_term    = mul_neg ? -$signed({1'b0, ki_capped}) : $signed({1'b0, ki_capped});
        total      = $signed({{16{acc_reg[48]}}, acc_reg}) + ki_term;
        if (total > 65'sh0_7FFF_FFFF) drive = 32'sh7FFF_FFFF;
        else if (total < -65'sh0_8000_0000) drive = 32'sh8000_0000;
        else drive = total[31:0];
    end

    // ---------------- sequencer ----------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:      if (s_tvalid) state_next = (in_sum != '0) ? S_MUL_CMD : S_ERR;
            S_MUL_CMD:   state_next = S_MUL_FILT;
            S_MUL_FILT:  state_next = S_SUM_NUM;
            S_SUM_NUM:   state_next = S_DIV_RATE;
            S_DIV_RATE:  state_next = S_WAIT_RATE;
            S_WAIT_RATE: if (div_done) state_next = S_DIV_FILT;
            S_DIV_FILT:  state_next = S_WAIT_FILT;
            S_WAIT_FILT: if (div_done) state_next = S_ERR;
            S_ERR:       state_next = S_MUL_P;
            S_MUL_P:     state_next = S_INTEG;
            S_INTEG:     state_next = S_MUL_KD;
            S_MUL_KD:    state_next = S_MUL_KI_HI;
            S_MUL_KI_HI: state_next = S_MUL_KI_LO;
            S_MUL_KI_LO: state_next = S_RESULT;
            S_RESULT:    if (!m_tvalid_reg || m_tready) state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    always_comb begin
        s_tready    = 1'b0;
        div_start   = 1'b0;
        out_load    = 1'b0;
        mul_req.en  = 1'b1;
        mul_req.neg = 1'b0;
        mul_req.a   = '0;
        mul_req.b   = '0;
        case (state_reg)
            S_IDLE: begin
                // no beat is taken while reset is held
                s_tready = aresetn;
            end
            S_MUL_CMD: begin
                mul_req.a   = {12'h000, dt_reg};
                mul_req.b   = mag32(cmd_reg);
                mul_req.neg = cmd_reg[31];
            end
            S_MUL_FILT: begin
                mul_req.a   = {12'h000, tau_reg};
                mul_req.b   = mag32(filt_reg);
                mul_req.neg = filt_reg[31];
            end
            S_DIV_RATE, S_DIV_FILT: begin
                div_start = 1'b1;
            end
            S_MUL_P: begin
                mul_req.a   = {12'h000, dt_reg};
                mul_req.b   = mag32(p_reg);
                mul_req.neg = p_reg[31];
            end
            S_INTEG: begin
                mul_req.a   = mag32($signed(kp_reg));
                mul_req.b   = mag32(p_reg);
                mul_req.neg = kp_reg[31] ^ p_reg[31];
            end
            S_MUL_KD: begin
                mul_req.a   = mag32($signed(kd_reg));
                mul_req.b   = mag32(d_reg);
                mul_req.neg = kd_reg[31] ^ d_reg[31];
            end
            S_MUL_KI_HI: begin
                mul_req.a   = mag32($signed(ki_reg));
                mul_req.b   = integ_mag[47:16];
                mul_req.neg = ki_reg[31] ^ integ_reg[INTEG_W-1];
            end
            S_MUL_KI_LO: begin
                mul_req.a   = mag32($signed(ki_reg));
                mul_req.b   = {16'h0000, integ_mag[15:0]};
                mul_req.neg = ki_reg[31] ^ integ_reg[INTEG_W-1];
            end
            S_RESULT: begin
                // hold the low product while the result slot is busy
                mul_req.en = 1'b0;
                out_load   = !m_tvalid_reg || m_tready;
            end
            default: begin
                mul_req.en = 1'b1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= S_IDLE;
        else state_reg <= state_next;
    end

    // ---------------- configuration ----------------
    assign cfg_ready = aresetn;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kp_reg  <= '0;
            ki_reg  <= '0;
            kd_reg  <= '0;
            tau_reg <= '0;
            lim_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_GAIN_PROP:  kp_reg  <= cfg_data;
                REG_GAIN_INTEG: ki_reg  <= cfg_data;
                REG_GAIN_DERIV: kd_reg  <= cfg_data;
                REG_FILTER_TC:  tau_reg <= cfg_data[TIME_W-1:0];
                REG_CMD_LIMIT:  lim_reg <= cfg_data[LIMIT_W-1:0];
                default:        ;
            endcase
        end
    end

    // ---------------- working registers ----------------
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            cmd_reg   <= in_cmd_clamped;
            meas_reg  <= $signed(s_tdata[63:32]);
            mrate_reg <= $signed(s_tdata[95:64]);
            dt_reg    <= in_dt;
            sum_reg   <= in_sum;
        end
        case (state_reg)
            S_MUL_FILT: num_reg <= prod_s[53:0];
            S_SUM_NUM:  num_reg <= num_reg + prod_s[53:0];
            S_ERR: begin
                p_reg <= sat33({filt_reg[31], filt_reg} - {meas_reg[31], meas_reg});
                d_reg <= sat33({rate_reg[31], rate_reg} - {mrate_reg[31], mrate_reg});
            end
            S_MUL_KD:    acc_reg   <= q16_s;
            S_MUL_KI_HI: acc_reg   <= acc_reg + q16_s;
            S_MUL_KI_LO: ki_hi_reg <= mul_prod;
            default:     ;
        endcase
    end

    // Filter and integrator state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filt_reg  <= '0;
            rate_reg  <= '0;
            integ_reg <= '0;
        end else begin
            if (state_reg == S_WAIT_RATE && div_done)
                rate_reg <= sat_quot(diff33[32], div_quot);
            if (state_reg == S_WAIT_FILT && div_done)
                filt_reg <= sat_quot(num_reg[53], div_quot);
            if (state_reg == S_INTEG) begin
                if (integ_wide[48] != integ_wide[47])
                    integ_reg <= integ_wide[48] ? {1'b1, {(INTEG_W-1){1'b0}}}
                                                : {1'b0, {(INTEG_W-1){1'b1}}};
                else
                    integ_reg <= integ_wide[INTEG_W-1:0];
            end
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) m_tdata_reg <= drive;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTH
    a_div_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == S_WAIT_RATE || state_reg == S_WAIT_FILT))
        else $error("divider finished outside a wait state");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept |=> !s_tready)
        else $error("input accepted while a tick is in progress");

    a_zero_sum_holds_filter: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && in_sum == '0) |=> ##1 ($stable(filt_reg) && $stable(rate_reg)))
        else $error("filter state moved with a zero filter sum");

    a_result_shown: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> m_tvalid)
        else $error("result load did not raise m_tvalid");
`endif

endmodule

`default_nettype wire

@@ bench/pid_with_command_filter_core_tb.sv @@
// Self-checking bench for pid_with_command_filter_core: a directed table, then random phases.
// Expected drive values come from a fixed-point predictor in this file, or from the table for checked rows.
// Needs pwcf_pkg and the core RTL.
`default_nettype none

module pid_with_command_filter_core_tb
    import pwcf_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          RESET_CYCLES  = 11;
    localparam int          DRAIN_CYCLES  = 150;
    localparam int unsigned CYCLE_LIMIT   = 1_000_000;
    localparam int          RANDOM_PHASES = 8;
    localparam int          PHASE_ITEMS   = 85;
    localparam int          FILL_W        = S_TDATA_W - 3 * DATA_W - TIME_W;

    localparam logic [DATA_W-1:0] Q_MAX  = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] Q_MIN  = 32'h8000_0000;
    localparam logic [TIME_W-1:0] T_MAX  = 20'hF_FFFF;
    localparam longint            Q16_ONE = 65536;
    localparam longint unsigned   PRODUCT_CAP = 64'd1 << 62;

    // Indexes past the last register; writes there must be ignored
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_FIRST = CFG_INDEX_W'(REG_CMD_LIMIT + 1);
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LAST  = '1;

    typedef struct {
        bit                     is_write;
        logic [CFG_INDEX_W-1:0] index;
        logic [DATA_W-1:0]      value;
        logic [DATA_W-1:0]      command;
        logic [DATA_W-1:0]      measured;
        logic [DATA_W-1:0]      measured_rate;
        logic [TIME_W-1:0]      time_step;
        bit                     typed;
        logic [DATA_W-1:0]      drive;
    } stim_row_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [DATA_W-1:0]      cfg_data  = '0;

    // Predictor copies of the registers and the controller state
    logic signed [DATA_W-1:0] gain_kp = '0;
    logic signed [DATA_W-1:0] gain_ki = '0;
    logic signed [DATA_W-1:0] gain_kd = '0;
    logic [TIME_W-1:0]        tau_reg = '0;
    logic [LIMIT_W-1:0]       limit_reg = '0;
    longint                   filt_cmd = 0;
    longint                   cmd_rate = 0;
    longint                   integ_sum = 0;

    logic [DATA_W-1:0] drive_pending[$];
    logic [DATA_W-1:0] want_drive;
    stim_row_t         directed_rows[$];
    int                failures = 0;
    int                sender_idle_pct = 0;
    int                rcv_stall_pct = 0;
    int unsigned       cycle_count = 0;

    pid_with_command_filter_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // command, measured, measured_rate, time_step, zero fill
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // drive
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("pid_with_command_filter_core regression: fail");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99, 0) >= rcv_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (drive_pending.size() == 0) begin
                $error("drive: expected nothing, got %h", m_tdata);
                failures++;
            end else begin
                want_drive = drive_pending.pop_front();
                if (m_tdata !== want_drive) begin
                    $error("drive: expected %h, got %h", want_drive, m_tdata);
                    failures++;
                end
            end
        end
    end

    function automatic longint saturate(input longint v, input int w);
        longint hi;
        longint lo;
        hi = (64'sd1 <<< (w - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    // Signed product dropped to Q.16 toward zero, magnitude capped at 2^62
    function automatic longint scaled_product(input longint a, input longint b);
        longint unsigned ua;
        longint unsigned ub;
        longint unsigned m;
        ua = (a < 0) ? -a : a;
        ub = (b < 0) ? -b : b;
        m = ua * (ub >> 16) + ((ua * (ub & 64'hFFFF)) >> 16);
        if (m > PRODUCT_CAP) m = PRODUCT_CAP;
        return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
    endfunction

    function automatic void load_register(input logic [CFG_INDEX_W-1:0] index,
                                          input logic [DATA_W-1:0] value);
        case (index)
            REG_GAIN_PROP:  gain_kp = value;
            REG_GAIN_INTEG: gain_ki = value;
            REG_GAIN_DERIV: gain_kd = value;
            REG_FILTER_TC:  tau_reg = value[TIME_W-1:0];
            REG_CMD_LIMIT:  limit_reg = value[LIMIT_W-1:0];
            default: ;
        endcase
    endfunction

    // Advance filter, rate and integral by one tick and return the drive
    function automatic logic [DATA_W-1:0] pid_drive_next(
        input logic signed [DATA_W-1:0] command,
        input logic signed [DATA_W-1:0] measured,
        input logic signed [DATA_W-1:0] measured_rate,
        input logic [TIME_W-1:0]        time_step
    );
        longint cmd;
        longint lim;
        longint dt;
        longint s;
        longint p;
        longint d;
        longint acc;
        cmd = command;
        lim = longint'(limit_reg);
        dt  = longint'(time_step);
        s   = dt + longint'(tau_reg);
        if (lim > 0) begin
            if (cmd > lim) cmd = lim;
            else if (cmd < -lim) cmd = -lim;
        end
        // Zero filter sum: hold filtered command and rate
        if (s > 0) begin
            cmd_rate = saturate(((cmd - filt_cmd) * Q16_ONE) / s, 32);
            filt_cmd = saturate((dt * cmd + longint'(tau_reg) * filt_cmd) / s, 32);
        end
        p = saturate(filt_cmd - longint'(measured), 32);
        d = saturate(cmd_rate - longint'(measured_rate), 32);
        integ_sum = saturate(integ_sum + (dt * p) / Q16_ONE, INTEG_W);
        acc = scaled_product(longint'(gain_kp), p) + scaled_product(longint'(gain_kd), d);
        acc = saturate(acc, 50);
        acc = saturate(acc + scaled_product(longint'(gain_ki), integ_sum), 32);
        return acc[DATA_W-1:0];
    endfunction

    function automatic stim_row_t item_row(input logic [DATA_W-1:0] command,
                                           input logic [DATA_W-1:0] measured,
                                           input logic [DATA_W-1:0] measured_rate,
                                           input logic [TIME_W-1:0] time_step);
        stim_row_t row;
        row = '{default: '0};
        row.command       = command;
        row.measured      = measured;
        row.measured_rate = measured_rate;
        row.time_step     = time_step;
        return row;
    endfunction

    function automatic stim_row_t checked_row(input logic [DATA_W-1:0] command,
                                              input logic [DATA_W-1:0] measured,
                                              input logic [DATA_W-1:0] measured_rate,
                                              input logic [TIME_W-1:0] time_step,
                                              input logic [DATA_W-1:0] drive);
        stim_row_t row;
        row = item_row(command, measured, measured_rate, time_step);
        row.typed = 1'b1;
        row.drive = drive;
        return row;
    endfunction

    function automatic stim_row_t write_row(input logic [CFG_INDEX_W-1:0] index,
                                            input logic [DATA_W-1:0] value);
        stim_row_t row;
        row = '{default: '0};
        row.is_write = 1'b1;
        row.index    = index;
        row.value    = value;
        return row;
    endfunction

    function automatic void add_row(input stim_row_t row);
        directed_rows = {directed_rows, row};
    endfunction

    function automatic logic [DATA_W-1:0] rand_q16();
        case ($urandom_range(3, 0))
            0: return $urandom();
            1: begin
                case ($urandom_range(4, 0))
                    0: return Q_MAX;
                    1: return Q_MIN;
                    2: return '0;
                    3: return '1;
                    default: return 32'h1;
                endcase
            end
            default: return $urandom_range(32'h00FF_FFFF, 0) - 32'h0080_0000;
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] jitter();
        return $urandom_range(32'h1_FFFF, 0) - 32'h1_0000;
    endfunction

    function automatic logic [TIME_W-1:0] rand_step();
        case ($urandom_range(3, 0))
            0: return '0;
            1: return T_MAX;
            2: return TIME_W'($urandom_range(T_MAX, 0));
            default: return TIME_W'($urandom_range(32'h2000, 1));
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] rand_gain();
        case ($urandom_range(3, 0))
            0: begin
                case ($urandom_range(2, 0))
                    0: return Q_MAX;
                    1: return Q_MIN;
                    default: return '0;
                endcase
            end
            1: return $urandom();
            default: return $urandom_range(32'h0008_0000, 0) - 32'h0004_0000;
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] rand_tau();
        case ($urandom_range(3, 0))
            0: return '0;
            1: return $urandom();
            2: return DATA_W'(T_MAX);
            default: return $urandom_range(32'h4000, 1);
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] rand_limit();
        case ($urandom_range(3, 0))
            0: return '0;
            1: return $urandom();
            2: return Q_MAX;
            default: return $urandom_range(32'h0100_0000, 1);
        endcase
    endfunction

    task automatic send_item(input stim_row_t row);
        logic [DATA_W-1:0] predicted;
        cfg_valid <= 1'b0;
        while ($urandom_range(99, 0) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {FILL_W'(0), row.time_step, row.measured_rate, row.measured, row.command};
        do @(posedge aclk); while (!s_tready);
        predicted = pid_drive_next(row.command, row.measured, row.measured_rate,
                                   row.time_step);
        if (row.typed) predicted = row.drive;
        drive_pending = {drive_pending, predicted};
    endtask

    // Write only once every pending drive beat has come back
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [DATA_W-1:0] value);
        s_tvalid <= 1'b0;
        while (drive_pending.size() != 0) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        load_register(index, value);
    endtask

    initial begin
        logic [DATA_W-1:0]      setpoint;
        logic [CFG_INDEX_W-1:0] spare_index;
        stim_row_t              row;
        int                     phase;
        int                     n;

        // Reset state and zero gains read back as zero drive
        add_row(checked_row('0, '0, '0, '0, '0));
        add_row(checked_row(Q_MAX, Q_MIN, Q_MIN, T_MAX, '0));
        // Filter now sits at full scale; hold it with a zero step
        add_row(write_row(REG_GAIN_PROP, Q_MAX));
        add_row(checked_row('0, Q_MIN, '0, '0, Q_MAX));
        add_row(write_row(REG_GAIN_PROP, Q_MIN));
        add_row(checked_row('0, Q_MIN, '0, '0, Q_MIN));
        // Command clamp at +/- 3.0
        add_row(write_row(REG_GAIN_PROP, 32'h0001_0000));
        add_row(write_row(REG_CMD_LIMIT, 32'h0003_0000));
        add_row(item_row(32'h7FFF_0000, '0, '0, 20'h1_0000));
        add_row(item_row(Q_MIN, '0, '0, 20'h1_0000));
        add_row(item_row(32'h0003_0000, 32'h0001_0000, '0, 20'h0_4000));
        add_row(item_row(32'hFFFD_0000, '0, '0, 20'h0_4000));
        // Top bit of the limit is dropped; tiny step saturates the rate both ways
        add_row(write_row(REG_CMD_LIMIT, 32'hFFFF_FFFF));
        add_row(item_row(Q_MIN, '0, '0, 20'h1));
        add_row(item_row(Q_MAX, '0, '0, 20'h1));
        add_row(write_row(REG_GAIN_PROP, '0));
        add_row(write_row(REG_GAIN_DERIV, Q_MAX));
        add_row(item_row('0, '0, Q_MIN, '0));
        add_row(write_row(REG_GAIN_DERIV, Q_MIN));
        add_row(item_row('0, '0, Q_MAX, '0));
        // Full-scale time constant, clamp off
        add_row(write_row(REG_FILTER_TC, 32'hFFFF_FFFF));
        add_row(write_row(REG_CMD_LIMIT, '0));
        add_row(write_row(REG_GAIN_DERIV, 32'h0000_8000));
        add_row(item_row(Q_MIN, Q_MAX, Q_MAX, T_MAX));
        add_row(item_row(32'h0010_0000, 32'h0001_0000, 32'hFFFF_0000, '0));
        add_row(write_row(REG_GAIN_INTEG, Q_MAX));
        add_row(item_row(32'h0020_0000, Q_MIN, '0, T_MAX));
        add_row(write_row(REG_GAIN_INTEG, Q_MIN));
        add_row(item_row(32'h0020_0000, Q_MAX, '0, T_MAX));
        add_row(write_row(REG_SPARE_FIRST, Q_MAX));
        add_row(write_row(REG_SPARE_LAST, Q_MAX));
        add_row(item_row(32'h0020_0000, 32'h0010_0000, 32'h1, 20'h0_1000));
        // Zero filter sum with live state
        add_row(write_row(REG_FILTER_TC, '0));
        add_row(item_row(Q_MAX, 32'h1234_5678, '1, '0));

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            if (directed_rows[i].is_write) write_reg(directed_rows[i].index,
                                                     directed_rows[i].value);
            else send_item(directed_rows[i]);
        end

        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            write_reg(REG_GAIN_PROP, rand_gain());
            write_reg(REG_GAIN_INTEG, rand_gain());
            write_reg(REG_GAIN_DERIV, rand_gain());
            write_reg(REG_FILTER_TC, rand_tau());
            write_reg(REG_CMD_LIMIT, rand_limit());
            if ($urandom_range(1, 0) == 1) begin
                spare_index = CFG_INDEX_W'($urandom_range(REG_SPARE_LAST, REG_SPARE_FIRST));
                write_reg(spare_index, $urandom());
            end
            case (phase % 4)
                0: begin sender_idle_pct = 0;  rcv_stall_pct = 0;  end
                1: begin sender_idle_pct = 74; rcv_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  rcv_stall_pct = 74; end
                default: begin sender_idle_pct = 31; rcv_stall_pct = 31; end
            endcase
            setpoint = rand_q16();
            for (n = 0; n < PHASE_ITEMS; n++) begin
                if (n == PHASE_ITEMS / 2) begin
                    // Hold off until the core has drained
                    s_tvalid <= 1'b0;
                    while (drive_pending.size() != 0) @(posedge aclk);
                end
                if ($urandom_range(19, 0) == 0) setpoint = rand_q16();
                // Mostly a tracking loop near the set point, the rest raw noise
                if ($urandom_range(4, 0) != 0)
                    row = item_row(setpoint + jitter(), setpoint + jitter(), jitter(),
                                   TIME_W'($urandom_range(32'h1000, 1)));
                else
                    row = item_row(rand_q16(), rand_q16(), rand_q16(), rand_step());
                send_item(row);
            end
        end

        s_tvalid <= 1'b0;
        while (drive_pending.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (failures == 0)
            $display("pid_with_command_filter_core regression: pass");
        else
            $display("pid_with_command_filter_core regression: fail");
        $finish;
    end

endmodule

`default_nettype wire

@@ pid_with_command_filter_core.f @@
rtl/core/pwcf_pkg.sv
rtl/core/pwcf_div.sv
rtl/core/pwcf_mul.sv
rtl/core/pid_with_command_filter_core.sv
bench/pid_with_command_filter_core_tb.sv
